FILE: sv/tkat_pkg.sv
// ----------------------------------------------------------------------------
// tkat_pkg
// Shared types and constants for the top-k address table: the table size,
// the request types, the action codes, the slot entry, the request and result transactions, and the shift control.
// ----------------------------------------------------------------------------
package tkat_pkg;

    // Number of slots in the table (1 to 8)
    localparam int TABLE_SLOTS = 8;
    localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TABLE_SLOTS - 1);

    // Request types
    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    // Result action codes
    localparam logic [2:0] ACT_IGNORE  = 3'd0;
    localparam logic [2:0] ACT_REFRESH = 3'd1;
    localparam logic [2:0] ACT_INSERT  = 3'd2;
    localparam logic [2:0] ACT_REPLACE = 3'd3;
    localparam logic [2:0] ACT_DROP    = 3'd4;
    localparam logic [2:0] ACT_READ    = 3'd5;

    // One table slot
    typedef struct packed {
        logic [31:0] addr;
        logic        is_ipv6;
        logic [15:0] proto;
        logic [31:0] count;
    } tkat_entry_t;

    // Request transaction
    typedef struct packed {
        logic        req_type;
        logic [31:0] ip_addr;
        logic        is_ipv6;
        logic [15:0] proto_code;
        logic [31:0] hit_count;
        logic [2:0]  read_slot;
    } tkat_in_t;

    // Result transaction
    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  slot;
        logic [31:0] entry_addr;
        logic        entry_is_ipv6;
        logic [15:0] entry_proto;
        logic [31:0] entry_count;
    } tkat_out_t;

    // Shift control from the controller to the cell chain
    typedef struct packed {
        logic        en;
        tkat_entry_t data;
    } tkat_shift_t;

endpackage

FILE: sv/tkat_cell.sv
// ----------------------------------------------------------------------------
// tkat_cell
// One slot of the table. Holds an entry and hands it to its neighbor
// toward the head of the chain on every shift.
// ----------------------------------------------------------------------------
module tkat_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  shift_en,
    input  tkat_pkg::tkat_entry_t d,
    output tkat_pkg::tkat_entry_t q
);
    import tkat_pkg::*;

    tkat_entry_t entry_reg;

    // Load the neighbor's entry on a shift, hold otherwise
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else if (shift_en)
        begin
            entry_reg <= d;
        end
    end

    assign q = entry_reg;

endmodule

FILE: sv/tkat_ctrl.sv
// ----------------------------------------------------------------------------
// tkat_ctrl
// Sequencer of the table. Watches the entry at the head of the rotating
// cell chain: a scan pass looks for a match, an empty slot and the minimum
// count; a write pass puts the modified entry back and captures the result.
// ----------------------------------------------------------------------------
module tkat_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tkat_pkg::tkat_in_t    in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output tkat_pkg::tkat_out_t   out_data,
    input  tkat_pkg::tkat_entry_t head,
    output tkat_pkg::tkat_shift_t shift
);
    import tkat_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    tkat_in_t          req_reg, req_next;
    logic [2:0]        kind_reg, kind_next;
    logic [SLOT_W-1:0] tgt_reg, tgt_next;
    logic              hit_reg, hit_next;
    logic              found_reg, found_next;
    logic [31:0]       best_reg, best_next;
    logic [SLOT_W-1:0] best_idx_reg, best_idx_next;
    tkat_out_t         res_reg, res_next;
    tkat_out_t         out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            hit_reg       <= hit_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        kind_reg     <= kind_next;
        tgt_reg      <= tgt_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    // Sequence one transaction through scan and write passes
    always_comb
    begin
        tkat_entry_t new_e;
        tkat_entry_t mod_e;
        logic        last;

        state_next     = state_reg;
        idx_next       = idx_reg;
        req_next       = req_reg;
        kind_next      = kind_reg;
        tgt_next       = tgt_reg;
        hit_next       = hit_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        new_e.addr    = req_reg.ip_addr;
        new_e.is_ipv6 = req_reg.is_ipv6;
        new_e.proto   = req_reg.proto_code;
        new_e.count   = req_reg.hit_count;
        mod_e         = head;
        last          = (idx_reg == LAST_IDX);

        shift.en   = 1'b0;
        shift.data = head;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next      = in_data;
                    idx_next      = '0;
                    hit_next      = 1'b0;
                    found_next    = 1'b0;
                    best_next     = in_data.hit_count;
                    best_idx_next = '0;
                    res_next      = '0;
                    if (in_data.req_type == REQ_READ)
                    begin
                        if (32'(in_data.read_slot) < 32'(TABLE_SLOTS))
                        begin
                            kind_next  = ACT_READ;
                            tgt_next   = SLOT_W'(in_data.read_slot);
                            state_next = ST_WRITE;
                        end
                        else
                        begin
                            res_next.action = ACT_READ;
                            res_next.slot   = in_data.read_slot;
                            state_next      = ST_DONE;
                        end
                    end
                    else if (in_data.hit_count == 32'd0)
                    begin
                        res_next.action = ACT_IGNORE;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // Rotate unchanged; note the first match or empty slot
                shift.en = 1'b1;
                if (!hit_reg)
                begin
                    if (head.addr == req_reg.ip_addr)
                    begin
                        hit_next  = 1'b1;
                        kind_next = ACT_REFRESH;
                        tgt_next  = idx_reg;
                    end
                    else if (head.count == 32'd0)
                    begin
                        hit_next  = 1'b1;
                        kind_next = ACT_INSERT;
                        tgt_next  = idx_reg;
                    end
                end
                // Track the lowest-index strictly smaller count
                if (head.count < best_reg)
                begin
                    best_next     = head.count;
                    best_idx_next = idx_reg;
                    found_next    = 1'b1;
                end
                if (last)
                begin
                    idx_next = '0;
                    if (hit_next)
                    begin
                        state_next = ST_WRITE;
                    end
                    else if (found_next)
                    begin
                        kind_next  = ACT_REPLACE;
                        tgt_next   = best_idx_next;
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        res_next        = '0;
                        res_next.action = ACT_DROP;
                        state_next      = ST_DONE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end

            ST_WRITE:
            begin
                // Rotate, modifying the target entry as it passes the head
                shift.en = 1'b1;
                if (idx_reg == tgt_reg)
                begin
                    case (kind_reg) inside
                        ACT_REFRESH:
                        begin
                            mod_e.count = req_reg.hit_count;
                        end
                        ACT_INSERT, ACT_REPLACE:
                        begin
                            mod_e = new_e;
                        end
                        default:
                        begin
                            mod_e = head;
                        end
                    endcase
                    shift.data             = mod_e;
                    res_next.action        = kind_reg;
                    res_next.slot          = 3'(idx_reg);
                    res_next.entry_addr    = mod_e.addr;
                    res_next.entry_is_ipv6 = mod_e.is_ipv6;
                    res_next.entry_proto   = mod_e.proto;
                    res_next.entry_count   = mod_e.count;
                end
                if (last)
                begin
                    idx_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end

            ST_DONE:
            begin
                // Hand the result to the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: sv/top_k_address_table.sv
// ----------------------------------------------------------------------------
// top_k_address_table
// Table of address/count slots that keeps the largest counters, built as a
// rotating chain of slot cells with one compare unit at the head.
// ----------------------------------------------------------------------------
// Sequence from input accept to result valid: an update runs a scan pass and
//   then a write pass over the slots, a dropped update only the scan pass, a
//   read only the write pass, and an ignored update neither.
// Flow: one transaction at a time; the next is accepted when the result is
//   raised; a result still waiting at the output holds the block until it is taken.
// Reset: asynchronous, clears every slot to empty at once; no clearing pass.
// ----------------------------------------------------------------------------
module top_k_address_table (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tkat_pkg::tkat_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tkat_pkg::tkat_out_t out_data
);
    import tkat_pkg::*;

    tkat_entry_t cell_q [TABLE_SLOTS];
    tkat_shift_t shift;

    // Sequencer with the head compare unit
    tkat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .head      (cell_q[0]),
        .shift     (shift)
    );

    // Chain of slot cells; the tail takes the entry fed back from the head
    genvar g;
    generate
        for (g = 0; g < TABLE_SLOTS; g++)
        begin : g_cell
            if (g == TABLE_SLOTS - 1)
            begin : g_tail
                tkat_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (shift.en),
                    .d        (shift.data),
                    .q        (cell_q[g])
                );
            end
            else
            begin : g_body
                tkat_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (shift.en),
                    .d        (cell_q[g+1]),
                    .q        (cell_q[g])
                );
            end
        end
    endgenerate

    // The chain never rotates while the block waits for a transaction
    a_idle_no_shift: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !shift.en)
        else $error("cell chain shifted while idle");

    // An accepted transaction occupies the block in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("block ready right after accepting a transaction");

    // Ignored and dropped results carry no slot and no entry
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.action == ACT_IGNORE || out_data.action == ACT_DROP))
        |-> (out_data.slot == 3'd0 && out_data.entry_count == 32'd0
             && out_data.entry_addr == 32'd0))
        else $error("ignored or dropped result carries entry data");

    // A slot written by an update always holds a nonzero count
    a_written_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.action == ACT_REFRESH || out_data.action == ACT_INSERT
                       || out_data.action == ACT_REPLACE))
        |-> (out_data.entry_count != 32'd0))
        else $error("updated slot holds a zero count");

endmodule

FILE: bench/top_k_address_table_tb.sv
// ----------------------------------------------------------------------------
// top_k_address_table_tb
// Self-checking bench for the top-k address table. A driver pushes update and
// read transactions from a queue; a monitor keeps its own copy of the slot
// table, predicts each result and compares it field by field with the DUT.
// ----------------------------------------------------------------------------
module top_k_address_table_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tkat_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 374;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    tkat_in_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    tkat_out_t out_data;

    // Bench copy of the slot table
    logic [31:0] shadow_addr  [TABLE_SLOTS];
    logic [31:0] shadow_count [TABLE_SLOTS];
    logic        shadow_ver   [TABLE_SLOTS];
    logic [15:0] shadow_proto [TABLE_SLOTS];

    tkat_in_t    request_queue[$];
    tkat_out_t   pending_reports[$];
    logic [31:0] addr_pool [16];

    bit in_taken    = 1'b0;
    int sent_count  = 0;
    int total_items = 1;
    int errors      = 0;
    int cycle_count = 0;
    int send_idle_pct;
    int recv_idle_pct;

    top_k_address_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Idle rates per phase: sender light / receiver heavy, then swapped, then none
    assign send_idle_pct = (sent_count < total_items / 3) ? 21 :
                           (sent_count < 2 * total_items / 3) ? 57 : 0;
    assign recv_idle_pct = (sent_count < total_items / 3) ? 57 :
                           (sent_count < 2 * total_items / 3) ? 21 : 0;

    // Build the report for one slot as it stands now
    function automatic tkat_out_t slot_view(input logic [2:0] act, input int idx);
        tkat_out_t rep;
        rep        = '0;
        rep.action = act;
        rep.slot   = idx[2:0];
        if (idx < TABLE_SLOTS)
        begin
            rep.entry_addr    = shadow_addr[idx];
            rep.entry_is_ipv6 = shadow_ver[idx];
            rep.entry_proto   = shadow_proto[idx];
            rep.entry_count   = shadow_count[idx];
        end
        return rep;
    endfunction

    // Apply one request to the bench table and return the expected report
    function automatic tkat_out_t apply_to_table(input tkat_in_t req);
        tkat_out_t   rep;
        logic [31:0] best;
        int          best_idx;
        bit          found;
        rep = '0;
        if (req.req_type == REQ_READ)
            return slot_view(ACT_READ, int'(req.read_slot));
        if (req.hit_count == 32'd0)
        begin
            rep.action = ACT_IGNORE;
            return rep;
        end
        // first pass: first slot that matches the address or is empty, in slot order
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            if (shadow_addr[i] == req.ip_addr)
            begin
                shadow_count[i] = req.hit_count;
                return slot_view(ACT_REFRESH, i);
            end
            if (shadow_count[i] == 32'd0)
            begin
                shadow_addr[i]  = req.ip_addr;
                shadow_ver[i]   = req.is_ipv6;
                shadow_proto[i] = req.proto_code;
                shadow_count[i] = req.hit_count;
                return slot_view(ACT_INSERT, i);
            end
        end
        // second pass: lowest-index smallest count strictly below the new one
        best     = req.hit_count;
        best_idx = 0;
        found    = 1'b0;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            if (shadow_count[i] < best)
            begin
                best     = shadow_count[i];
                best_idx = i;
                found    = 1'b1;
            end
        end
        if (!found)
        begin
            rep.action = ACT_DROP;
            return rep;
        end
        shadow_addr[best_idx]  = req.ip_addr;
        shadow_ver[best_idx]   = req.is_ipv6;
        shadow_proto[best_idx] = req.proto_code;
        shadow_count[best_idx] = req.hit_count;
        return slot_view(ACT_REPLACE, best_idx);
    endfunction

    // Compare one result transaction with its prediction
    task automatic check_report(input tkat_out_t exp, input tkat_out_t got);
        if (got.action !== exp.action)
        begin
            $error("action: expected %0d, got %0d", exp.action, got.action);
            errors++;
        end
        if (got.slot !== exp.slot)
        begin
            $error("slot: expected %0d, got %0d", exp.slot, got.slot);
            errors++;
        end
        if (got.entry_addr !== exp.entry_addr)
        begin
            $error("entry_addr: expected %h, got %h", exp.entry_addr, got.entry_addr);
            errors++;
        end
        if (got.entry_is_ipv6 !== exp.entry_is_ipv6)
        begin
            $error("entry_is_ipv6: expected %0d, got %0d",
                   exp.entry_is_ipv6, got.entry_is_ipv6);
            errors++;
        end
        if (got.entry_proto !== exp.entry_proto)
        begin
            $error("entry_proto: expected %h, got %h", exp.entry_proto, got.entry_proto);
            errors++;
        end
        if (got.entry_count !== exp.entry_count)
        begin
            $error("entry_count: expected %h, got %h", exp.entry_count, got.entry_count);
            errors++;
        end
    endtask

    // Queue an update; the unused slot field gets random bits
    task automatic push_update(input logic [31:0] addr, input logic ver,
                               input logic [15:0] proto, input logic [31:0] cnt);
        tkat_in_t req;
        req.req_type   = REQ_UPDATE;
        req.ip_addr    = addr;
        req.is_ipv6    = ver;
        req.proto_code = proto;
        req.hit_count  = cnt;
        req.read_slot  = 3'($urandom_range(7));
        request_queue.push_back(req);
    endtask

    // Queue a read; the unused update fields get random bits
    task automatic push_read(input logic [2:0] idx);
        tkat_in_t req;
        req.req_type   = REQ_READ;
        req.ip_addr    = $urandom;
        req.is_ipv6    = 1'($urandom_range(1));
        req.proto_code = 16'($urandom);
        req.hit_count  = $urandom;
        req.read_slot  = idx;
        request_queue.push_back(req);
    endtask

    // Pick a random count, mostly small so that replacements and drops mix
    function automatic logic [31:0] random_count();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
            return 32'($urandom_range(1, 64));
        if (pick < 85)
            return 32'($urandom_range(1, 4096));
        if (pick < 95)
            return $urandom;
        return 32'hFFFF_FFFF;
    endfunction

    // Driver: present the next request at the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
            if (!in_valid || in_taken)
            begin
                if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_data    <= request_queue.pop_front();
                    in_valid   <= 1'b1;
                    sent_count <= sent_count + 1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: predict on accepted requests, check accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= in_valid && in_ready;
            if (out_valid && out_ready)
            begin
                if (pending_reports.size() == 0)
                begin
                    $error("result with no request outstanding: action %0d slot %0d",
                           out_data.action, out_data.slot);
                    errors++;
                end
                else
                begin
                    check_report(pending_reports.pop_front(), out_data);
                end
            end
            if (in_valid && in_ready)
                pending_reports.push_back(apply_to_table(in_data));
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("top_k_address_table test failed");
            $finish;
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int pick;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            shadow_addr[i]  = '0;
            shadow_count[i] = '0;
            shadow_ver[i]   = 1'b0;
            shadow_proto[i] = '0;
        end
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 16; i++)
            addr_pool[i] = $urandom;

        // empty slot read, then address zero matching an empty slot
        push_read(3'd0);
        push_update(32'h0000_0000, 1'b1, 16'h1234, 32'd5);
        // extreme entry into the first truly empty slot
        push_update(32'hFFFF_FFFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
        // same address with the other version tag still matches
        push_update(32'hFFFF_FFFF, 1'b0, 16'h0000, 32'd3);
        // zero count is ignored
        push_update(32'h0A00_0001, 1'b1, 16'hAAAA, 32'd0);
        // fill the rest of the table
        push_update(32'h0A00_0002, 1'b0, 16'h0050, 32'd10);
        push_update(32'h0A00_0003, 1'b1, 16'h01BB, 32'd20);
        push_update(32'h0A00_0004, 1'b0, 16'h0035, 32'd2);
        push_update(32'h0A00_0005, 1'b1, 16'h5555, 32'd40);
        push_update(32'h0A00_0006, 1'b0, 16'h8000, 32'd50);
        push_update(32'h0A00_0007, 1'b1, 16'h7FFF, 32'd60);
        // full table: equal to the minimum and below it are dropped
        push_update(32'hC0A8_0001, 1'b1, 16'h0001, 32'd2);
        push_update(32'hC0A8_0002, 1'b0, 16'h0002, 32'd1);
        // replace the minimum
        push_update(32'hC0A8_0003, 1'b1, 16'h0003, 32'd4);
        // lower a count to make a tie, then lowest index of the tie goes
        push_update(32'h0A00_0007, 1'b0, 16'h0000, 32'd3);
        push_update(32'hDEAD_BEEF, 1'b0, 16'hBEEF, 32'd100);
        push_update(32'h0A00_0002, 1'b1, 16'h0000, 32'hFFFF_FFFF);
        push_update(32'h1234_5678, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < 8; i++)
            push_read(3'(i));

        // random mix: pooled addresses keep refreshes and replacements going
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 20)
                push_read(3'($urandom_range(7)));
            else if (pick < 25)
                push_update($urandom, 1'($urandom_range(1)), 16'($urandom), 32'd0);
            else
                push_update(($urandom_range(99) < 65) ? addr_pool[$urandom_range(15)]
                                                      : $urandom,
                            1'($urandom_range(1)), 16'($urandom), random_count());
        end
        total_items = request_queue.size();

        // hold reset, then release it at a falling edge
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // drain: all requests sent and every result back
        while (request_queue.size() != 0 || in_valid || pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("top_k_address_table test passed");
        else
            $display("top_k_address_table test failed");
        $finish;
    end

endmodule

FILE: files.f
sv/tkat_pkg.sv
sv/tkat_cell.sv
sv/tkat_ctrl.sv
sv/top_k_address_table.sv
bench/top_k_address_table_tb.sv
